/* rtl/core/rtp_header_keyframe_parser_defines.svh */
// Assertion macros used by the top-level parser
`ifndef RTP_HEADER_KEYFRAME_PARSER_DEFINES_SVH
`define RTP_HEADER_KEYFRAME_PARSER_DEFINES_SVH

// Same-cycle implication
`define RHKP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RHKP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rhkp_pkg.sv */
package rhkp_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65535;
    localparam int unsigned WALK_W = 18;

    localparam logic [WALK_W-1:0] KEY_NONE = '1;

    // codec register codes
    localparam logic [1:0] CODEC_H264 = 2'd1;
    localparam logic [1:0] CODEC_H265 = 2'd2;

    // NAL unit type codes
    localparam logic [4:0] H264_IDR    = 5'd5;
    localparam logic [4:0] H264_STAP_A = 5'd24;
    localparam logic [4:0] H264_FU_A   = 5'd28;
    localparam logic [5:0] H265_AP     = 6'd48;
    localparam logic [5:0] H265_FU     = 6'd49;
    localparam logic [5:0] H265_IRAP_LO = 6'd16;
    localparam logic [5:0] H265_IRAP_HI = 6'd23;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    typedef struct packed {
        logic        parsed_ok;
        logic [6:0]  rtp_pt;
        logic        marker_bit;
        logic [15:0] sequence_number;
        logic [31:0] rtp_timestamp;
        logic [31:0] source_id;
        logic [15:0] header_length;
        logic [15:0] payload_length;
        logic        is_keyframe;
    } t_result;

    function automatic logic is_irap(input logic [5:0] t);
        return (t >= H265_IRAP_LO) && (t <= H265_IRAP_HI);
    endfunction

endpackage

/* rtl/core/rhkp_front.sv */
module rhkp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last,
    input  logic [1:0]       i_codec,
    output logic             o_res_valid,
    output rhkp_pkg::t_result o_res
);

    logic [16:0] r_pos,  n_pos;
    logic [3:0]  r_cc,   n_cc;
    logic        r_ext,  n_ext;
    logic        r_vg,   n_vg;
    logic [7:0]  r_ptm,  n_ptm;
    logic [15:0] r_seq,  n_seq;
    logic [31:0] r_ts,   n_ts;
    logic [31:0] r_ssrc, n_ssrc;
    logic [18:0] r_hl,   n_hl;
    logic [7:0]  r_exth, n_exth;
    logic [7:0]  r_head0, n_head0;
    logic [17:0] r_nsp,  n_nsp;
    logic [7:0]  r_ush,  n_ush;
    logic [17:0] r_uhp,  n_uhp;
    logic [17:0] r_fke,  n_fke;
    logic        r_kd,   n_kd;

    logic        active;
    logic [7:0]  b;
    logic [16:0] ext_at;
    logic [18:0] pos19;
    logic [17:0] pos18;
    logic        pay;
    logic        nsp_set;
    logic [17:0] nsp_cur;
    logic        qual;
    logic [16:0] total;
    logic        ok;

    assign b     = i_data_byte;
    assign pos19 = {2'b00, r_pos};
    assign pos18 = {1'b0, r_pos};
    assign active = i_accept && (r_pos < 17'(rhkp_pkg::MAX_PACKET_BYTES));
    assign ext_at = 17'd12 + {11'd0, r_cc, 2'b00};

    // Parse one byte
    always_comb begin
        n_pos = r_pos; n_cc = r_cc; n_ext = r_ext; n_vg = r_vg; n_ptm = r_ptm;
        n_seq = r_seq; n_ts = r_ts; n_ssrc = r_ssrc; n_hl = r_hl; n_exth = r_exth;
        n_head0 = r_head0; n_nsp = r_nsp; n_ush = r_ush; n_uhp = r_uhp;
        n_fke = r_fke; n_kd = r_kd;
        pay = 1'b0; nsp_set = 1'b0; qual = 1'b0; nsp_cur = r_nsp;
        if (active) begin
            n_pos = r_pos + 17'd1;
            if (r_pos == 17'd0) begin
                n_vg  = (b[7:6] == 2'd2);
                n_cc  = b[3:0];
                n_ext = b[4];
                n_hl  = 19'd12 + {13'd0, b[3:0], 2'b00} + (b[4] ? 19'd4 : 19'd0);
            end else if (r_pos == 17'd1) begin
                n_ptm = b;
            end else if (r_pos < 17'd4) begin
                n_seq = {r_seq[7:0], b};
            end else if (r_pos < 17'd8) begin
                n_ts = {r_ts[23:0], b};
            end else if (r_pos < 17'd12) begin
                n_ssrc = {r_ssrc[23:0], b};
            end else begin
                // header extension length
                if (r_ext && r_pos == ext_at + 17'd2) n_exth = b;
                if (r_ext && r_pos == ext_at + 17'd3)
                    n_hl = r_hl + {1'b0, r_exth, b, 2'b00};
                pay = (pos19 >= n_hl);
            end

            // classify the payload head
            if (pay) begin
                if (pos19 == n_hl) n_head0 = b;
                if (i_codec == rhkp_pkg::CODEC_H264) begin
                    if (pos19 == n_hl) begin
                        if (b[4:0] == rhkp_pkg::H264_IDR) n_kd = 1'b1;
                        if (b[4:0] == rhkp_pkg::H264_STAP_A) nsp_set = 1'b1;
                    end else if (pos19 == n_hl + 19'd1) begin
                        if (r_head0[4:0] == rhkp_pkg::H264_FU_A && b[7]
                            && b[4:0] == rhkp_pkg::H264_IDR) n_kd = 1'b1;
                    end
                end else if (i_codec == rhkp_pkg::CODEC_H265) begin
                    if (pos19 == n_hl + 19'd1) begin
                        if (rhkp_pkg::is_irap(r_head0[6:1])) n_kd = 1'b1;
                        if (r_head0[6:1] == rhkp_pkg::H265_AP) nsp_set = 1'b1;
                    end else if (pos19 == n_hl + 19'd2) begin
                        if (r_head0[6:1] == rhkp_pkg::H265_FU && b[7]
                            && rhkp_pkg::is_irap(b[5:0])) n_kd = 1'b1;
                    end
                end
                nsp_cur = nsp_set ? (pos18 + 18'd1) : r_nsp;
                n_nsp = nsp_cur;

                // walk aggregation units
                if (nsp_cur != 18'd0) begin
                    if (r_uhp != 18'd0 && pos18 == r_uhp && r_fke == rhkp_pkg::KEY_NONE) begin
                        if (i_codec == rhkp_pkg::CODEC_H264)
                            qual = (nsp_cur > r_uhp) && (b[4:0] == rhkp_pkg::H264_IDR);
                        else if (i_codec == rhkp_pkg::CODEC_H265)
                            qual = ({1'b0, nsp_cur} >= {1'b0, r_uhp} + 19'd2)
                                && rhkp_pkg::is_irap(b[6:1]);
                        if (qual) n_fke = nsp_cur;
                    end
                    if (pos18 == nsp_cur) begin
                        n_ush = b;
                    end else if (pos18 == nsp_cur + 18'd1) begin
                        n_uhp = pos18 + 18'd1;
                        n_nsp = pos18 + 18'd1 + {2'b00, r_ush, b};
                    end
                end
            end
        end
    end

    // Build the result beat
    assign total = r_pos + 17'd1;
    assign ok = (r_pos < 17'(rhkp_pkg::MAX_PACKET_BYTES)) && n_vg && (total >= 17'd12)
             && ({2'b00, total} >= n_hl);
    assign o_res_valid = i_accept && i_last;

    always_comb begin
        o_res = '0;
        if (ok) begin
            o_res.parsed_ok       = 1'b1;
            o_res.rtp_pt          = n_ptm[6:0];
            o_res.marker_bit      = n_ptm[7];
            o_res.sequence_number = n_seq;
            o_res.rtp_timestamp   = n_ts;
            o_res.source_id       = n_ssrc;
            o_res.header_length   = n_hl[15:0];
            o_res.payload_length  = 16'(({2'b00, total} - n_hl));
            o_res.is_keyframe     = n_kd || (n_fke <= {1'b0, total});
        end
    end

    // Advance, or clear on reset or at the end of a packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_pos <= '0; r_cc <= '0; r_ext <= 1'b0; r_vg <= 1'b0; r_ptm <= '0;
            r_seq <= '0; r_ts <= '0; r_ssrc <= '0; r_hl <= 19'd12; r_exth <= '0;
            r_head0 <= '0; r_nsp <= '0; r_ush <= '0; r_uhp <= '0;
            r_fke <= rhkp_pkg::KEY_NONE; r_kd <= 1'b0;
        end else begin
            r_pos <= n_pos; r_cc <= n_cc; r_ext <= n_ext; r_vg <= n_vg; r_ptm <= n_ptm;
            r_seq <= n_seq; r_ts <= n_ts; r_ssrc <= n_ssrc; r_hl <= n_hl; r_exth <= n_exth;
            r_head0 <= n_head0; r_nsp <= n_nsp; r_ush <= n_ush; r_uhp <= n_uhp;
            r_fke <= n_fke; r_kd <= n_kd;
        end
    end

endmodule

/* rtl/core/rhkp_queue.sv */
module rhkp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  rhkp_pkg::t_result i_data,
    input  logic              i_rd,
    output logic              o_full,
    output logic              o_empty,
    output rhkp_pkg::t_result o_data
);

    rhkp_pkg::t_result r_mem [rhkp_pkg::QDEPTH];
    logic [rhkp_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [rhkp_pkg::QCNT_W-1:0] r_cnt;
    logic do_rd;

    function automatic logic [rhkp_pkg::QCNT_W-1:0] QCNT_ONE(input logic v);
        return {{(rhkp_pkg::QCNT_W-1){1'b0}}, v};
    endfunction

    assign o_full  = (r_cnt == rhkp_pkg::QCNT_W'(rhkp_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    // Move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_wr)  r_wp <= r_wp + 1'b1;
            if (do_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_ONE(i_wr) - QCNT_ONE(do_rd);
        end
    end

endmodule

/* rtl/core/rtp_header_keyframe_parser.sv */
// RTP header parser with H.264/H.265 keyframe detection. Feed a packet one
// byte per beat on i_data_byte, with i_last on its final byte; every packet
// yields exactly one result beat. A byte is taken every cycle unless full is
// high, which only happens once the four-entry result queue holds four unread
// results; the parser handles each byte with combinational compares and counters.
// A result is readable the cycle after its last byte. Write the codec register
// (0 none, 1 H.264, 2 H.265) only between packets.
`include "rtp_header_keyframe_parser_defines.svh"

module rtp_header_keyframe_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic        o_parsed_ok,
    output logic [6:0]  o_rtp_pt,
    output logic        o_marker_bit,
    output logic [15:0] o_sequence_number,
    output logic [31:0] o_rtp_timestamp,
    output logic [31:0] o_source_id,
    output logic [15:0] o_header_length,
    output logic [15:0] o_payload_length,
    output logic        o_is_keyframe,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_codec
);

    logic [1:0] r_codec;
    logic       accept;
    logic       res_valid;
    rhkp_pkg::t_result res, q_out;

    // Hold the codec
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_codec <= '0;
        else if (i_cfg_we) r_codec <= i_cfg_codec;
    end

    assign accept = push && !full;

    rhkp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_codec     (r_codec),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rhkp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_data  (res),
        .i_rd    (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (q_out)
    );

    assign o_parsed_ok       = q_out.parsed_ok;
    assign o_rtp_pt          = q_out.rtp_pt;
    assign o_marker_bit      = q_out.marker_bit;
    assign o_sequence_number = q_out.sequence_number;
    assign o_rtp_timestamp   = q_out.rtp_timestamp;
    assign o_source_id       = q_out.source_id;
    assign o_header_length   = q_out.header_length;
    assign o_payload_length  = q_out.payload_length;
    assign o_is_keyframe     = q_out.is_keyframe;

    `RHKP_ASSERT_NOW(a_not_full_and_empty, i_clk, i_rst_n,
        1'b1, !(full && empty), "queue both full and empty")
    `RHKP_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n,
        accept && i_last, !empty, "no result after last beat")
    `RHKP_ASSERT_NEXT(a_mid_byte_no_result, i_clk, i_rst_n,
        accept && !i_last && !pop && !empty, !empty, "result lost on mid-packet beat")
    `RHKP_ASSERT_NOW(a_invalid_zeroed, i_clk, i_rst_n,
        !empty && !o_parsed_ok, !o_is_keyframe && o_header_length == 16'd0,
        "invalid result not cleared")

endmodule
